[rtl/ptdp_pkg.sv]
// Shared types, widths and constants of the pan/tilt deadband controller.
`default_nettype none
package ptdp_pkg;

   localparam int TAG_W      = 32;
   localparam int CENTROID_W = 16;
   localparam int SIZE_W     = 13;
   localparam int FRAC_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int CMD_W      = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // quotient bits of the normalising and rescaling dividers
   localparam int NORM_Q_W   = 15;
   localparam int RESC_Q_W   = 16;

   // input register, normalise divider, prep, rescale divider, multiply, clamp
   localparam int LANE_LAT   = 1 + NORM_Q_W + 1 + RESC_Q_W + 2;

   localparam logic [SIZE_W-1:0]  WIDTH_RST  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0]  HEIGHT_RST = SIZE_W'(480);
   localparam logic [FRAC_W-1:0]  FLOOR_RST  = FRAC_W'(32768);
   localparam logic [FRAC_W-1:0]  DEAD_RST   = FRAC_W'(3277);
   localparam logic [GAIN_W-1:0]  GAIN_RST   = GAIN_W'(4096);
   localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(4096);

   typedef enum logic [1:0] {
      STATUS_TRACK    = 2'd0,
      STATUS_LOW_CONF = 2'd1,
      STATUS_BAD_DIM  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_IMAGE_WIDTH  = 3'd0,
      CFG_IMAGE_HEIGHT = 3'd1,
      CFG_CONF_FLOOR   = 3'd2,
      CFG_DEAD_ZONE    = 3'd3,
      CFG_PAN_GAIN     = 3'd4,
      CFG_TILT_GAIN    = 3'd5,
      CFG_PAN_LIMIT    = 3'd6,
      CFG_TILT_LIMIT   = 3'd7
   } cfg_index_type;

endpackage
`default_nettype wire

[rtl/pan_tilt_deadband_p_controller.sv]
// Top level: configuration registers, pan and tilt lanes, result merge.
// Path: a beat accepted goes through the lane input register, normalise divider, prep,
//   rescale divider, multiply and clamp, then the merge register, before its result
//   strobe; the delay is set mostly by the two bit-per-stage dividers.
// Throughput: one beat per cycle unless busy; busy is high only in and just after reset.
// Reset (synchronous, active high) clears all valid bits and reloads the registers
//   with their defaults; busy is high in the cycle after reset so nothing is taken.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
`default_nettype none
module pan_tilt_deadband_p_controller
   import ptdp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [TAG_W-1:0]         req_frame_tag,
   input  wire logic [CENTROID_W-1:0]    req_centroid_x,
   input  wire logic [CENTROID_W-1:0]    req_centroid_y,
   input  wire logic [FRAC_W-1:0]        req_estimate_confidence,
   // response channel
   output logic                          rsp_valid,
   output logic [TAG_W-1:0]              rsp_frame_tag_out,
   output logic signed [CMD_W-1:0]       rsp_pan_setpoint,
   output logic signed [CMD_W-1:0]       rsp_tilt_setpoint,
   output logic [1:0]                    rsp_track_status,
   // configuration port
   input  wire logic                     csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [SIZE_W-1:0]        width_ff;
   logic [SIZE_W-1:0]        height_ff;
   logic [FRAC_W-1:0]        floor_ff;
   logic [FRAC_W-1:0]        dead_ff;
   logic signed [GAIN_W-1:0] pan_gain_ff;
   logic signed [GAIN_W-1:0] tilt_gain_ff;
   logic [LIMIT_W-1:0]       pan_limit_ff;
   logic [LIMIT_W-1:0]       tilt_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RST;
         height_ff     <= HEIGHT_RST;
         floor_ff      <= FLOOR_RST;
         dead_ff       <= DEAD_RST;
         pan_gain_ff   <= GAIN_RST;
         tilt_gain_ff  <= GAIN_RST;
         pan_limit_ff  <= LIMIT_RST;
         tilt_limit_ff <= LIMIT_RST;
      end else if (csr_write_en) begin
         case (cfg_index_type'(csr_index))
            CFG_IMAGE_WIDTH:  width_ff      <= csr_wdata[SIZE_W-1:0];
            CFG_IMAGE_HEIGHT: height_ff     <= csr_wdata[SIZE_W-1:0];
            CFG_CONF_FLOOR:   floor_ff      <= csr_wdata[FRAC_W-1:0];
            CFG_DEAD_ZONE:    dead_ff       <= csr_wdata[FRAC_W-1:0];
            CFG_PAN_GAIN:     pan_gain_ff   <= $signed(csr_wdata[GAIN_W-1:0]);
            CFG_TILT_GAIN:    tilt_gain_ff  <= $signed(csr_wdata[GAIN_W-1:0]);
            CFG_PAN_LIMIT:    pan_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CFG_TILT_LIMIT:   tilt_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Request accept; busy while reset is held and for the cycle after reset
   // ------------------------------------------------------------------
   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // status decided at accept; low confidence takes priority
   status_type status_in;

   always_comb begin
      if (req_estimate_confidence < floor_ff) begin
         status_in = STATUS_LOW_CONF;
      end else if (width_ff == '0 || height_ff == '0) begin
         status_in = STATUS_BAD_DIM;
      end else begin
         status_in = STATUS_TRACK;
      end
   end

   // tag and status ride alongside the lanes in a delay line
   logic [TAG_W-1:0] tag_ff    [LANE_LAT];
   status_type       status_ff [LANE_LAT];

   always_ff @(posedge clock) begin
      tag_ff[0]    <= req_frame_tag;
      status_ff[0] <= status_in;
      for (int i = 1; i < LANE_LAT; i++) begin
         tag_ff[i]    <= tag_ff[i-1];
         status_ff[i] <= status_ff[i-1];
      end
   end

   // ------------------------------------------------------------------
   // Axis lanes
   // ------------------------------------------------------------------
   logic                    pan_valid;
   logic signed [CMD_W-1:0] pan_cmd;
   logic                    tilt_valid;
   logic signed [CMD_W-1:0] tilt_cmd;

   ptdp_lane u_pan_lane (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .centroid  (req_centroid_x),
      .size      (width_ff),
      .dead_zone (dead_ff),
      .gain      (pan_gain_ff),
      .limit     (pan_limit_ff),
      .out_valid (pan_valid),
      .out_cmd   (pan_cmd)
   );

   ptdp_lane u_tilt_lane (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .centroid  (req_centroid_y),
      .size      (height_ff),
      .dead_zone (dead_ff),
      .gain      (tilt_gain_ff),
      .limit     (tilt_limit_ff),
      .out_valid (tilt_valid),
      .out_cmd   (tilt_cmd)
   );

   // ------------------------------------------------------------------
   // Merge: zero both setpoints unless tracking
   // ------------------------------------------------------------------
   logic                    rsp_valid_ff;
   logic [TAG_W-1:0]        rsp_tag_ff;
   logic signed [CMD_W-1:0] rsp_pan_ff;
   logic signed [CMD_W-1:0] rsp_tilt_ff;
   status_type              rsp_status_ff;
   logic                    tracking;

   assign tracking = status_ff[LANE_LAT-1] == STATUS_TRACK;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pan_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tag_ff    <= tag_ff[LANE_LAT-1];
      rsp_status_ff <= status_ff[LANE_LAT-1];
      rsp_pan_ff    <= tracking ? pan_cmd : '0;
      rsp_tilt_ff   <= tracking ? tilt_cmd : '0;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_tag_out = rsp_tag_ff;
   assign rsp_pan_setpoint  = rsp_pan_ff;
   assign rsp_tilt_setpoint = rsp_tilt_ff;
   assign rsp_track_status  = rsp_status_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      pan_valid == tilt_valid)
      else $error("pan and tilt lanes out of step");

   a_lane_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LANE_LAT pan_valid)
      else $error("lane result missing at the expected cycle");

   a_rsp_from_lane : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(pan_valid))
      else $error("response strobe without a lane result");

   a_zero_when_not_tracking : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_track_status != STATUS_TRACK |->
         rsp_pan_setpoint == '0 && rsp_tilt_setpoint == '0)
      else $error("setpoints not zeroed on a rejected estimate");

endmodule
`default_nettype wire

[rtl/ptdp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module ptdp_div
   import ptdp_pkg::*;
#(
   parameter int DVS_W  = SIZE_W,
   parameter int Q_W    = NORM_Q_W,
   parameter int SIDE_W = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [DVS_W-1:0]  in_rem,     // must be below divisor
   input  wire logic [Q_W-1:0]    in_low,     // dividend bits still to shift in
   input  wire logic [SIDE_W-1:0] in_side,
   input  wire logic [DVS_W-1:0]  divisor,
   output logic                   out_valid,
   output logic [Q_W-1:0]         out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   logic [DVS_W-1:0]  rem_ff   [Q_W];
   logic [Q_W-1:0]    low_ff   [Q_W];
   logic [Q_W-1:0]    quo_ff   [Q_W];
   logic [SIDE_W-1:0] side_ff  [Q_W];
   logic              valid_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [DVS_W-1:0]  rem_prev;
      logic [Q_W-1:0]    low_prev;
      logic [Q_W-1:0]    quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [DVS_W:0]    trial;
      logic              ge;
      logic [DVS_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign rem_prev   = in_rem;
         assign low_prev   = in_low;
         assign quo_prev   = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign low_prev   = low_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign trial  = {rem_prev, low_prev[Q_W-1]};
      assign ge     = trial >= {1'b0, divisor};
      assign rem_in = ge ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         low_ff[k]  <= {low_prev[Q_W-2:0], 1'b0};
         quo_ff[k]  <= {quo_prev[Q_W-2:0], ge};
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quo   = quo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule
`default_nettype wire

[rtl/ptdp_lane.sv]
// One axis: normalise, deadband, rescale, gain and clamp.
`default_nettype none
module ptdp_lane
   import ptdp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [CENTROID_W-1:0]    centroid,
   input  wire logic [SIZE_W-1:0]        size,
   input  wire logic [FRAC_W-1:0]        dead_zone,
   input  wire logic signed [GAIN_W-1:0] gain,
   input  wire logic [LIMIT_W-1:0]       limit,
   output logic                          out_valid,
   output logic signed [CMD_W-1:0]       out_cmd
);

   // offset from the centre; centre is 8*size in Q12.4
   logic [CENTROID_W-1:0] centre;
   logic                  neg_in;
   logic [CENTROID_W-1:0] off_in;

   assign centre = CENTROID_W'({size, 3'b000});
   assign neg_in = centroid < centre;
   assign off_in = neg_in ? centre - centroid : centroid - centre;

   logic                  s0_valid_ff;
   logic [CENTROID_W-1:0] s0_off_ff;
   logic                  s0_neg_ff;
   logic                  s0_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s0_off_ff <= off_in;
      s0_neg_ff <= neg_in;
      // quotient would reach one: offset at least half the size
      s0_sat_ff <= off_in >= centre;
   end

   // off*4096/size: top bits are off>>3, then off[2:0] and twelve zeros
   logic                d1_valid;
   logic [NORM_Q_W-1:0] d1_quo;
   logic [1:0]          d1_side;

   ptdp_div #(
      .DVS_W  (SIZE_W),
      .Q_W    (NORM_Q_W),
      .SIDE_W (2)
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_rem    (SIZE_W'(s0_off_ff >> 3)),
      .in_low    (NORM_Q_W'({s0_off_ff[2:0], 12'd0})),
      .in_side   ({s0_neg_ff, s0_sat_ff}),
      .divisor   (size),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // saturate, double to Q0.16, remove deadband
   logic [NORM_Q_W-1:0] norm;
   logic [FRAC_W-1:0]   mag_in;

   assign norm   = d1_side[0] ? {NORM_Q_W{1'b1}} : d1_quo;
   assign mag_in = {norm, 1'b0};

   logic              p1_valid_ff;
   logic [FRAC_W-1:0] p1_diff_ff;
   logic              p1_neg_ff;
   logic              p1_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_diff_ff <= mag_in - dead_zone;
      p1_neg_ff  <= d1_side[1];
      p1_zero_ff <= mag_in <= dead_zone;
   end

   // (m - dz)*65536 / (65536 - dz)
   logic [FRAC_W:0]     resc_div;
   logic                d2_valid;
   logic [RESC_Q_W-1:0] d2_quo;
   logic [1:0]          d2_side;

   assign resc_div = {1'b1, {FRAC_W{1'b0}}} - {1'b0, dead_zone};

   ptdp_div #(
      .DVS_W  (FRAC_W + 1),
      .Q_W    (RESC_Q_W),
      .SIDE_W (2)
   ) u_resc_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p1_valid_ff),
      .in_rem    ({1'b0, p1_diff_ff}),
      .in_low    ('0),
      .in_side   ({p1_neg_ff, p1_zero_ff}),
      .divisor   (resc_div),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   // gain magnitude times rescaled error
   logic [GAIN_W:0]            gain_ext;
   logic [GAIN_W:0]            gain_mag;
   logic [GAIN_W+RESC_Q_W:0]   prod;

   assign gain_ext = {gain[GAIN_W-1], gain};
   assign gain_mag = gain[GAIN_W-1] ? (GAIN_W+1)'(~gain_ext + 1'b1) : gain_ext;
   assign prod     = gain_mag * d2_quo;

   logic              m1_valid_ff;
   logic [GAIN_W:0]   m1_mag_ff;
   logic              m1_neg_ff;
   logic              m1_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      m1_mag_ff  <= prod[GAIN_W+RESC_Q_W:RESC_Q_W];
      m1_neg_ff  <= d2_side[1] ^ gain[GAIN_W-1];
      m1_zero_ff <= d2_side[0];
   end

   // clamp and apply sign
   logic [LIMIT_W-1:0]    clamped;
   logic signed [CMD_W-1:0] cmd_in;

   assign clamped = (m1_mag_ff > (GAIN_W+1)'(limit)) ? limit : m1_mag_ff[LIMIT_W-1:0];

   always_comb begin
      if (m1_zero_ff) begin
         cmd_in = '0;
      end else if (m1_neg_ff) begin
         cmd_in = -$signed(CMD_W'(clamped));
      end else begin
         cmd_in = $signed(CMD_W'(clamped));
      end
   end

   logic                    c1_valid_ff;
   logic signed [CMD_W-1:0] c1_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_cmd_ff <= cmd_in;
   end

   assign out_valid = c1_valid_ff;
   assign out_cmd   = c1_cmd_ff;

endmodule
`default_nettype wire
